// File: src/iss_pkg.sv
// shared constants and types for the indexed sequence store
`default_nettype none
package iss_pkg;

	// fixed field widths
	localparam int OP_W       = 3;
	localparam int POS_W      = 6;
	localparam int VALUE_W    = 32;
	localparam int STATUS_W   = 2;
	localparam int COUNT_W    = 5;

	// widths that cover the full parameter range
	localparam int IDX_MAX_W  = 8;
	localparam int CNT_EXT_W  = 9;
	localparam int WIDE_W     = 64;

	// parameter defaults
	localparam int CAPACITY_DEF      = 16;
	localparam int ELEMENT_WIDTH_DEF = 32;

	// operation codes
	localparam logic [OP_W-1:0] OP_ADD_FRONT = 3'd0;
	localparam logic [OP_W-1:0] OP_ADD_REAR  = 3'd1;
	localparam logic [OP_W-1:0] OP_REM_FRONT = 3'd2;
	localparam logic [OP_W-1:0] OP_REM_REAR  = 3'd3;
	localparam logic [OP_W-1:0] OP_INSERT_AT = 3'd4;
	localparam logic [OP_W-1:0] OP_REMOVE_AT = 3'd5;

	// status codes
	localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] ST_UNDER = 2'd1;
	localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;
	localparam logic [STATUS_W-1:0] ST_OVER  = 2'd3;

	// shift command broadcast to every cell
	typedef struct packed {
		logic                 ins;
		logic                 rem;
		logic [IDX_MAX_W-1:0] idx;
	} shift_cmd_t;

endpackage
`default_nettype wire

// File: src/iss_cell.sv
// one storage cell of the shifting chain
`default_nettype none
module iss_cell #(
	parameter int IDX           = 0,
	parameter int ELEMENT_WIDTH = iss_pkg::ELEMENT_WIDTH_DEF
) (
	input  wire                      clk,
	input  iss_pkg::shift_cmd_t      cmd,
	input  wire [ELEMENT_WIDTH-1:0]  new_value,
	input  wire [ELEMENT_WIDTH-1:0]  left,
	input  wire [ELEMENT_WIDTH-1:0]  right,
	output logic [ELEMENT_WIDTH-1:0] data,
	output logic [ELEMENT_WIDTH-1:0] tap
);
	import iss_pkg::*;

	localparam logic [IDX_MAX_W-1:0] MY_IDX = IDX_MAX_W'(IDX);

	logic [ELEMENT_WIDTH-1:0] data_q;

	// insert: cells above the slot take the lower neighbor, the slot takes the new element
	// remove: the slot and cells above take the upper neighbor
	always_ff @(posedge clk) begin
		if (cmd.ins) begin
			if (MY_IDX > cmd.idx) begin
				data_q <= left;
			end else if (MY_IDX == cmd.idx) begin
				data_q <= new_value;
			end
		end else if (cmd.rem && MY_IDX >= cmd.idx) begin
			data_q <= right;
		end
	end

	assign data = data_q;
	// one-hot read of the element being removed
	assign tap  = (cmd.rem && MY_IDX == cmd.idx) ? data_q : '0;

endmodule
`default_nettype wire

// File: src/iss_ctrl.sv
// request decode: range checks, shift command and next count
`default_nettype none
module iss_ctrl #(
	parameter int CAPACITY = iss_pkg::CAPACITY_DEF,
	localparam int CNT_W   = $clog2(CAPACITY + 1)
) (
	input  wire                               accept,
	input  wire [iss_pkg::OP_W-1:0]           operation,
	input  wire [iss_pkg::POS_W-1:0]          position,
	input  wire [CNT_W-1:0]                   count,
	output iss_pkg::shift_cmd_t               cmd,
	output logic [iss_pkg::STATUS_W-1:0]      status,
	output logic [CNT_W-1:0]                  next_count
);
	import iss_pkg::*;

	localparam logic [CNT_EXT_W-1:0] CAP_EXT = CNT_EXT_W'(CAPACITY);

	logic [CNT_EXT_W-1:0] cnt_ext;
	logic [CNT_EXT_W-1:0] pos_ext;
	logic [CNT_EXT_W-1:0] pos_m1;
	logic [CNT_EXT_W-1:0] cnt_m1;
	logic                 full;
	logic                 empty;
	logic                 ins;
	logic                 rem;
	logic [CNT_EXT_W-1:0] idx;

	assign cnt_ext = CNT_EXT_W'(count);
	assign pos_ext = CNT_EXT_W'(position);
	assign pos_m1  = pos_ext - 1'b1;
	assign cnt_m1  = cnt_ext - 1'b1;
	assign full    = (cnt_ext == CAP_EXT);
	assign empty   = (cnt_ext == '0);

	always_comb begin
		status = ST_OK;
		ins    = 1'b0;
		rem    = 1'b0;
		idx    = '0;
		unique case (operation)
			OP_ADD_FRONT: begin
				if (full) status = ST_OVER;
				else ins = 1'b1;
			end
			OP_ADD_REAR: begin
				if (full) status = ST_OVER;
				else begin
					ins = 1'b1;
					idx = cnt_ext;
				end
			end
			OP_REM_FRONT: begin
				if (empty) status = ST_UNDER;
				else rem = 1'b1;
			end
			OP_REM_REAR: begin
				if (empty) status = ST_UNDER;
				else begin
					rem = 1'b1;
					idx = cnt_m1;
				end
			end
			OP_INSERT_AT: begin
				if (pos_ext == '0 || pos_ext > cnt_ext + 1'b1) status = ST_RANGE;
				else if (full) status = ST_OVER;
				else begin
					ins = 1'b1;
					idx = pos_m1;
				end
			end
			OP_REMOVE_AT: begin
				if (pos_ext == '0 || pos_ext > cnt_ext) status = ST_RANGE;
				else begin
					rem = 1'b1;
					idx = pos_m1;
				end
			end
			default: begin
				status = ST_OK;
			end
		endcase
	end

	assign cmd.ins = accept & ins;
	assign cmd.rem = accept & rem;
	assign cmd.idx = idx[IDX_MAX_W-1:0];

	always_comb begin
		next_count = count;
		if (cmd.ins) next_count = count + 1'b1;
		else if (cmd.rem) next_count = count - 1'b1;
	end

endmodule
`default_nettype wire

// File: src/indexed_sequence_store.sv
// top level of the indexed sequence store: control, cell chain and result register
`default_nettype none
// bounded ordered sequence with add/remove at front, rear or a 1-based position
//
// request channel: operation, position and value are taken at a rising edge
// with start high and busy low; busy stays low, so a request may come every cycle
// result channel: done is high for exactly one cycle, in the cycle after the request
// was taken, with removed_value, status, element_count and is_empty valid in that
// cycle; the receiver cannot stall, so nothing is held back for it
//
// throughput 1 request per cycle: every cell of the chain
// decides from the broadcast shift command whether to hold, take its lower
// neighbor, take its upper neighbor or load the new element, all at the same edge
//
// reset clears the element count and the result strobe; cell contents are not
// reset, and only cells below the count are ever read
// an add to a full store gives overflow and leaves the store unchanged
module indexed_sequence_store #(
	parameter int CAPACITY      = iss_pkg::CAPACITY_DEF,
	parameter int ELEMENT_WIDTH = iss_pkg::ELEMENT_WIDTH_DEF
) (
	input  wire                               clk,
	input  wire                               arst_n,
	input  wire                               start,
	output logic                              busy,
	input  wire [iss_pkg::OP_W-1:0]           operation,
	input  wire [iss_pkg::POS_W-1:0]          position,
	input  wire signed [iss_pkg::VALUE_W-1:0] value,
	output logic                              done,
	output logic signed [iss_pkg::VALUE_W-1:0] removed_value,
	output logic [iss_pkg::STATUS_W-1:0]      status,
	output logic [iss_pkg::COUNT_W-1:0]       element_count,
	output logic                              is_empty
);
	import iss_pkg::*;

	localparam int CNT_W = $clog2(CAPACITY + 1);

	// request side
	logic                     accept;
	shift_cmd_t               cmd;
	logic [STATUS_W-1:0]      op_status;
	logic [CNT_W-1:0]         next_count;
	logic [CNT_W-1:0]         count_q;

	// element path
	logic [WIDE_W-1:0]        value_wide;
	logic [ELEMENT_WIDTH-1:0] new_elem;
	logic [ELEMENT_WIDTH-1:0] cell_data [CAPACITY];
	logic [ELEMENT_WIDTH-1:0] cell_tap  [CAPACITY];
	logic [ELEMENT_WIDTH-1:0] tap_or;
	logic [WIDE_W-1:0]        tap_wide;

	// result register
	logic                     done_q;
	logic [VALUE_W-1:0]       removed_q;
	logic [STATUS_W-1:0]      status_q;
	logic [CNT_EXT_W-1:0]     count_wide;

	// one request per cycle, never held off
	assign busy   = 1'b0;
	assign accept = start & ~busy;

	iss_ctrl #(
		.CAPACITY (CAPACITY)
	) u_ctrl (
		.accept     (accept),
		.operation  (operation),
		.position   (position),
		.count      (count_q),
		.cmd        (cmd),
		.status     (op_status),
		.next_count (next_count)
	);

	// element keeps the low ELEMENT_WIDTH bits of the request value
	assign value_wide = WIDE_W'(unsigned'(value));
	assign new_elem   = value_wide[ELEMENT_WIDTH-1:0];

	// chain of cells; the ends feed back their own data where a neighbor is missing
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic [ELEMENT_WIDTH-1:0] left_n;
		logic [ELEMENT_WIDTH-1:0] right_n;

		if (i == 0) begin : g_lo
			assign left_n = cell_data[i];
		end else begin : g_lo
			assign left_n = cell_data[i-1];
		end

		if (i == CAPACITY - 1) begin : g_hi
			assign right_n = cell_data[i];
		end else begin : g_hi
			assign right_n = cell_data[i+1];
		end

		iss_cell #(
			.IDX           (i),
			.ELEMENT_WIDTH (ELEMENT_WIDTH)
		) u_cell (
			.clk       (clk),
			.cmd       (cmd),
			.new_value (new_elem),
			.left      (left_n),
			.right     (right_n),
			.data      (cell_data[i]),
			.tap       (cell_tap[i])
		);
	end

	// at most one tap is nonzero, so an or-tree picks the removed element
	always_comb begin
		tap_or = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			tap_or = tap_or | cell_tap[i];
		end
	end

	assign tap_wide = WIDE_W'(tap_or);

	// element count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else begin
			count_q <= next_count;
		end
	end

	// result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= accept;
		end
	end

	// result payload, captured with the request
	always_ff @(posedge clk) begin
		if (accept) begin
			removed_q <= tap_wide[VALUE_W-1:0];
			status_q  <= op_status;
		end
	end

	// count_q already holds the count after the request while done is high
	assign count_wide    = CNT_EXT_W'(count_q);
	assign done          = done_q;
	assign removed_value = signed'(removed_q);
	assign status        = status_q;
	assign element_count = count_wide[COUNT_W-1:0];
	assign is_empty      = (count_q == '0);

	// count stays within the capacity
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(CAPACITY))
		else $error("element count above capacity");

	// every request gives exactly one result in the next cycle
	a_one_result: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> done)
		else $error("request without result");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		!accept |=> !done)
		else $error("result without request");

	// a refused request leaves the count as it was and removes nothing
	a_refused_count: assert property (@(posedge clk) disable iff (!arst_n)
		accept && op_status != ST_OK |=> count_q == $past(count_q))
		else $error("refused request changed the count");

	a_refused_value: assert property (@(posedge clk) disable iff (!arst_n)
		done && status != ST_OK |-> removed_value == '0)
		else $error("refused request returned an element");

	// a successful add never goes into a full store
	a_ok_step: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.ins |-> count_q != CNT_W'(CAPACITY))
		else $error("insert into full store");

endmodule
`default_nettype wire
